// ===== hw/rtl/kerf_pkg.sv =====
// Package for the keyboard event router: item and decision types, result kinds,
// scancode constants and the set-1 UK keymap lookup.
// No dependencies; imported by kerf_route, the router top level and the testbench files.
package kerf_pkg;

	typedef enum logic [2:0] {
		KIND_QUEUED      = 3'd0,
		KIND_DROPPED     = 3'd1,
		KIND_ATTN_CHAR   = 3'd2,
		KIND_ABSORBED    = 3'd3,
		KIND_READ_RING   = 3'd4,
		KIND_READ_DIRECT = 3'd5
	} kind_t;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	localparam logic [6:0] ATTN_CODE    = 7'h46;
	localparam logic [7:0] DIRTY_MASK   = 8'he0;
	localparam logic [7:0] LSHIFT_MAKE  = 8'h2a;
	localparam logic [7:0] RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] LSHIFT_BREAK = 8'haa;
	localparam logic [7:0] RSHIFT_BREAK = 8'hb6;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] status;
		logic [7:0] scancode;
		logic       owner;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] key_char;
		logic [7:0] out_status;
		logic [7:0] out_scancode;
		logic       push;
		logic       pop;
		logic       attn_we;
		logic       attn_val;
		logic       shift_we;
		logic       shift_val;
	} route_t;

	// Set-1 UK keymap, plain and shifted; unlisted codes give no character.
	function automatic logic [6:0] keymap(input logic [6:0] code, input logic shift);
		logic [6:0] ch;
		ch = 7'h00;
		case (code)
			7'h02: ch = shift ? 7'h21 : 7'h31;
			7'h03: ch = shift ? 7'h22 : 7'h32;
			7'h04: ch = shift ? 7'h23 : 7'h33;
			7'h05: ch = shift ? 7'h24 : 7'h34;
			7'h06: ch = shift ? 7'h25 : 7'h35;
			7'h07: ch = shift ? 7'h5e : 7'h36;
			7'h08: ch = shift ? 7'h26 : 7'h37;
			7'h09: ch = shift ? 7'h2a : 7'h38;
			7'h0a: ch = shift ? 7'h28 : 7'h39;
			7'h0b: ch = shift ? 7'h29 : 7'h30;
			7'h0c: ch = shift ? 7'h5f : 7'h2d;
			7'h0d: ch = shift ? 7'h2b : 7'h3d;
			7'h0e: ch = 7'h08;
			7'h0f: ch = 7'h09;
			7'h10: ch = shift ? 7'h51 : 7'h71;
			7'h11: ch = shift ? 7'h57 : 7'h77;
			7'h12: ch = shift ? 7'h45 : 7'h65;
			7'h13: ch = shift ? 7'h52 : 7'h72;
			7'h14: ch = shift ? 7'h54 : 7'h74;
			7'h15: ch = shift ? 7'h59 : 7'h79;
			7'h16: ch = shift ? 7'h55 : 7'h75;
			7'h17: ch = shift ? 7'h49 : 7'h69;
			7'h18: ch = shift ? 7'h4f : 7'h6f;
			7'h19: ch = shift ? 7'h50 : 7'h70;
			7'h1a: ch = shift ? 7'h7b : 7'h5b;
			7'h1b: ch = shift ? 7'h7d : 7'h5d;
			7'h1c: ch = 7'h0d;
			7'h1e: ch = shift ? 7'h41 : 7'h61;
			7'h1f: ch = shift ? 7'h53 : 7'h73;
			7'h20: ch = shift ? 7'h44 : 7'h64;
			7'h21: ch = shift ? 7'h46 : 7'h66;
			7'h22: ch = shift ? 7'h47 : 7'h67;
			7'h23: ch = shift ? 7'h48 : 7'h68;
			7'h24: ch = shift ? 7'h4a : 7'h6a;
			7'h25: ch = shift ? 7'h4b : 7'h6b;
			7'h26: ch = shift ? 7'h4c : 7'h6c;
			7'h27: ch = shift ? 7'h3a : 7'h3b;
			7'h28: ch = shift ? 7'h40 : 7'h27;
			7'h29: ch = shift ? 7'h00 : 7'h60;
			7'h2b: ch = shift ? 7'h7e : 7'h23;
			7'h2c: ch = shift ? 7'h5a : 7'h7a;
			7'h2d: ch = shift ? 7'h58 : 7'h78;
			7'h2e: ch = shift ? 7'h43 : 7'h63;
			7'h2f: ch = shift ? 7'h56 : 7'h76;
			7'h30: ch = shift ? 7'h42 : 7'h62;
			7'h31: ch = shift ? 7'h4e : 7'h6e;
			7'h32: ch = shift ? 7'h4d : 7'h6d;
			7'h33: ch = shift ? 7'h3c : 7'h2c;
			7'h34: ch = shift ? 7'h3e : 7'h2e;
			7'h35: ch = shift ? 7'h3f : 7'h2f;
			7'h56: ch = shift ? 7'h7c : 7'h5c;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

endpackage

// ===== hw/rtl/kerf_ring.sv =====
// Event ring storage: one write port, one read port with registered read data.
// Depends on nothing; instantiated by keyboard_event_router_fifo.
module kerf_ring #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  logic [15:0]      wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output logic [15:0]      rd_data
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== hw/rtl/kerf_route.sv =====
// Routing decision for one captured request: attention key tracking, keymap
// translation, ring push or drop, and ring or direct read. Uses kerf_pkg.
module kerf_route (
	input  kerf_pkg::item_t  item,
	input  logic             attn_enable,
	input  logic             attn_held,
	input  logic             shift_held,
	input  logic             ring_empty,
	input  logic             ring_full,
	input  logic [15:0]      ring_data,
	output kerf_pkg::route_t dec
);
	import kerf_pkg::*;

	logic       clean;
	logic       is_attn;
	logic       to_ring;
	logic [6:0] ch;

	always_comb begin
		dec          = '0;
		dec.kind     = KIND_ABSORBED;
		to_ring      = 1'b1;
		ch           = 7'h00;
		clean        = attn_enable && ((item.status & DIRTY_MASK) == 8'h00);
		is_attn      = (item.scancode[6:0] == ATTN_CODE);

		if (item.cmd == CMD_READ) begin
			to_ring = 1'b0;
			if (ring_empty) begin
				dec.kind         = KIND_READ_DIRECT;
				dec.out_status   = item.status;
				dec.out_scancode = item.scancode;
			end else begin
				dec.kind         = KIND_READ_RING;
				dec.out_status   = ring_data[15:8];
				dec.out_scancode = ring_data[7:0];
				dec.pop          = 1'b1;
			end
		end else begin
			if (clean && is_attn) begin
				dec.attn_we  = 1'b1;
				dec.attn_val = ~item.scancode[7];
			end else if (clean && attn_held) begin
				// While the attention key is down, bytes feed the console keymap.
				to_ring = 1'b0;
				if (item.scancode == LSHIFT_BREAK || item.scancode == RSHIFT_BREAK) begin
					dec.shift_we  = 1'b1;
					dec.shift_val = 1'b0;
				end else if (item.scancode == LSHIFT_MAKE || item.scancode == RSHIFT_MAKE) begin
					dec.shift_we  = 1'b1;
					dec.shift_val = 1'b1;
				end else if (item.scancode[7]) begin
					ch = keymap(item.scancode[6:0], shift_held);
				end
				if (ch != 7'h00) begin
					dec.kind     = KIND_ATTN_CHAR;
					dec.key_char = ch;
				end else begin
					dec.kind = KIND_ABSORBED;
				end
			end
			if (to_ring) begin
				if (!item.owner) begin
					dec.kind = KIND_ABSORBED;
				end else if (ring_full) begin
					dec.kind = KIND_DROPPED;
				end else begin
					dec.kind = KIND_QUEUED;
					dec.push = 1'b1;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/keyboard_event_router_fifo.sv =====
// Keyboard event router top level: request capture, state machine, ring
// pointers, attention/shift flags and result registers.
// Depends on kerf_pkg, kerf_ring and kerf_route.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------------
//  request   | start / busy       | cmd, status, scancode, owner_present
//  result    | done (one cycle)   | kind, key_char, out_status, out_scancode
//  config    | cfg_we             | cfg_data (attention enable)
//
// On acceptance the accept edge also registers the ring entry at the read
// pointer, and the following cycle routes the request, writes the ring and
// loads the result registers. done is high in the cycle after that, while
// the next request may already be accepted. busy is high for one cycle
// per request. Reset clears pointers, flags and the state machine; the ring
// contents need no reset. Results cannot be held off by the receiver.
module keyboard_event_router_fifo #(
	parameter int RING_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       cmd,
	input  logic [7:0] status,
	input  logic [7:0] scancode,
	input  logic       owner_present,
	input  logic       cfg_we,
	input  logic       cfg_data,
	output logic       done,
	output logic [2:0] kind,
	output logic [6:0] key_char,
	output logic [7:0] out_status,
	output logic [7:0] out_scancode
);
	import kerf_pkg::*;

	localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	state_t           state_q, state_d;
	logic             accept;
	logic             exec_en;
	item_t            item_q;
	logic             attn_en_q;
	logic             attn_held_q;
	logic             shift_held_q;
	logic [IDX_W-1:0] wr_idx_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic [IDX_W-1:0] wr_next;
	logic [IDX_W-1:0] rd_next;
	logic [15:0]      ring_rdata;
	route_t           dec;
	logic             done_q;
	kind_t            kind_q;
	logic [6:0]       key_char_q;
	logic [7:0]       out_status_q;
	logic [7:0]       out_scancode_q;

	assign accept  = start && !busy;
	assign wr_next = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
	assign rd_next = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_EXEC;
			ST_EXEC: state_d = start ? ST_EXEC : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		// A request arriving while busy is not taken, so EXEC is always followed by IDLE.
		if (state_q == ST_EXEC) begin
			state_d = ST_IDLE;
		end
	end

	always_comb begin
		busy    = 1'b0;
		exec_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy    = 1'b0;
				exec_en = 1'b0;
			end
			ST_EXEC: begin
				busy    = 1'b1;
				exec_en = 1'b1;
			end
			default: begin
				busy    = 1'b0;
				exec_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.cmd      <= cmd_t'(cmd);
			item_q.status   <= status;
			item_q.scancode <= scancode;
			item_q.owner    <= owner_present;
		end
	end

	// The ring is read at the read pointer every cycle, so the entry is registered
	// at the accept edge; writes from earlier requests land before that edge.
	kerf_ring #(
		.DEPTH (RING_DEPTH),
		.IDX_W (IDX_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (exec_en && dec.push),
		.wr_addr (wr_idx_q),
		.wr_data ({item_q.status, item_q.scancode}),
		.rd_addr (rd_idx_q),
		.rd_data (ring_rdata)
	);

	kerf_route u_route (
		.item        (item_q),
		.attn_enable (attn_en_q),
		.attn_held   (attn_held_q),
		.shift_held  (shift_held_q),
		.ring_empty  (wr_idx_q == rd_idx_q),
		.ring_full   (wr_next == rd_idx_q),
		.ring_data   (ring_rdata),
		.dec         (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attn_en_q    <= 1'b1;
			attn_held_q  <= 1'b0;
			shift_held_q <= 1'b0;
			wr_idx_q     <= '0;
			rd_idx_q     <= '0;
			done_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				attn_en_q <= cfg_data;
			end
			done_q <= exec_en;
			if (exec_en) begin
				if (dec.attn_we) attn_held_q <= dec.attn_val;
				if (dec.shift_we) shift_held_q <= dec.shift_val;
				if (dec.push) wr_idx_q <= wr_next;
				if (dec.pop) rd_idx_q <= rd_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_en) begin
			kind_q         <= dec.kind;
			key_char_q     <= dec.key_char;
			out_status_q   <= dec.out_status;
			out_scancode_q <= dec.out_scancode;
		end
	end

	assign done         = done_q;
	assign kind         = kind_q;
	assign key_char     = key_char_q;
	assign out_status   = out_status_q;
	assign out_scancode = out_scancode_q;

`ifndef SYNTHESIS
	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy) else $error("request held busy for more than one cycle");

	a_accept_to_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted request not executed");

	a_busy_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done) else $error("executed request gave no result");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result strobe without a request");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_en && dec.push) |=> (wr_idx_q != rd_idx_q))
		else $error("ring write index overran the read index");
`endif

endmodule

// ===== tb/sv/kerf_event_checker.sv =====
`timescale 1ns / 1ps
// Checker for the keyboard event router: predicts every result from the accepted
// requests and configuration writes, and compares the results as they appear.
// Depends on kerf_pkg for the kind and command codes and the scancode constants.
module kerf_event_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       busy,
	input  logic       cmd,
	input  logic [7:0] status,
	input  logic [7:0] scancode,
	input  logic       owner_present,
	input  logic       cfg_we,
	input  logic       cfg_data,
	input  logic       done,
	input  logic [2:0] kind,
	input  logic [6:0] key_char,
	input  logic [7:0] out_status,
	input  logic [7:0] out_scancode,
	output int         fail_count,
	output int         outstanding,
	output int         checked,
	output logic [5:0] kinds_seen
);
	import kerf_pkg::*;

	typedef struct packed {
		kind_t      kind;
		logic [6:0] key_char;
		logic [7:0] status;
		logic [7:0] scancode;
	} outcome_t;

	// UK set-1 layout for codes 0x00 to 0x3f; every higher code except 0x56 is blank.
	localparam logic [0:63][7:0] PLAIN_MAP = {
		8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
		8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09,
		8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
		8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0d, 8'h00, 8'h61, 8'h73,
		8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
		8'h27, 8'h60, 8'h00, 8'h23, 8'h7a, 8'h78, 8'h63, 8'h76,
		8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 80'h0
	};
	localparam logic [0:63][7:0] SHIFT_MAP = {
		8'h00, 8'h00, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h5e,
		8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09,
		8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
		8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0d, 8'h00, 8'h41, 8'h53,
		8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
		8'h40, 8'h00, 8'h00, 8'h7e, 8'h5a, 8'h58, 8'h43, 8'h56,
		8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 80'h0
	};

	logic [15:0] slots [0:63];
	logic [5:0]  wr_ptr;
	logic [5:0]  rd_ptr;
	logic        attn_held;
	logic        shift_held;
	logic        attn_enable;
	outcome_t    expected_q [$];
	outcome_t    want;
	int          errs;
	int          results;
	logic [5:0]  seen;

	function automatic logic [6:0] glyph(input logic [6:0] code, input logic shifted);
		// The extra key beside left shift on UK boards sits outside the main block.
		if (code == 7'h56)
			return shifted ? 7'h7c : 7'h5c;
		if (code[6])
			return 7'h00;
		return shifted ? SHIFT_MAP[code[5:0]][6:0] : PLAIN_MAP[code[5:0]][6:0];
	endfunction

	function automatic outcome_t route_request(input cmd_t c, input logic [7:0] st,
			input logic [7:0] sc, input logic owner);
		outcome_t   o;
		logic       to_ring;
		logic [6:0] ch;
		o = '{KIND_ABSORBED, 7'h00, 8'h00, 8'h00};
		to_ring = 1'b1;
		ch = 7'h00;
		if (c == CMD_READ) begin
			if (wr_ptr == rd_ptr) begin
				o.kind = KIND_READ_DIRECT;
				o.status = st;
				o.scancode = sc;
			end else begin
				o.kind = KIND_READ_RING;
				o.status = slots[rd_ptr][15:8];
				o.scancode = slots[rd_ptr][7:0];
				rd_ptr = rd_ptr + 6'd1;
			end
			return o;
		end
		if (attn_enable && (st & DIRTY_MASK) == 8'h00) begin
			if (sc[6:0] == ATTN_CODE) begin
				attn_held = !sc[7];
			end else if (attn_held) begin
				to_ring = 1'b0;
				case (sc)
					LSHIFT_BREAK, RSHIFT_BREAK: shift_held = 1'b0;
					LSHIFT_MAKE, RSHIFT_MAKE: shift_held = 1'b1;
					default: if (sc[7]) ch = glyph(sc[6:0], shift_held);
				endcase
				if (ch != 7'h00) begin
					o.kind = KIND_ATTN_CHAR;
					o.key_char = ch;
				end
			end
		end
		if (to_ring) begin
			if (!owner) begin
				o.kind = KIND_ABSORBED;
			end else if (wr_ptr + 6'd1 == rd_ptr) begin
				o.kind = KIND_DROPPED;
			end else begin
				slots[wr_ptr] = {st, sc};
				wr_ptr = wr_ptr + 6'd1;
				o.kind = KIND_QUEUED;
			end
		end
		return o;
	endfunction

	function automatic int differs(input string field, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (got_v === want_v)
			return 0;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr = 6'd0;
			rd_ptr = 6'd0;
			attn_held = 1'b0;
			shift_held = 1'b0;
			attn_enable = 1'b1;
			expected_q.delete();
			errs = 0;
			results = 0;
			seen = 6'b0;
			fail_count <= 0;
			outstanding <= 0;
			checked <= 0;
			kinds_seen <= 6'b0;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$display("%0t: result kind %0h arrived with no request outstanding",
						$time, kind);
					errs++;
				end else begin
					want = expected_q.pop_front();
					errs += differs("kind", 8'(want.kind), 8'(kind));
					errs += differs("key_char", 8'(want.key_char), 8'(key_char));
					errs += differs("out_status", want.status, out_status);
					errs += differs("out_scancode", want.scancode, out_scancode);
					results++;
					if (kind <= 3'd5)
						seen[kind] = 1'b1;
				end
			end
			if (cfg_we)
				attn_enable = cfg_data;
			if (start && !busy)
				expected_q.push_back(route_request(cmd_t'(cmd), status, scancode,
					owner_present));
			fail_count <= errs;
			outstanding <= expected_q.size();
			checked <= results;
			kinds_seen <= seen;
		end
	end

endmodule

// ===== tb/sv/tb_keyboard_event_router_fifo.sv =====
`timescale 1ns / 1ps
// Top of the keyboard event router testbench: clock, reset, request stimulus in
// phases of attention setting and idling, and the verdict.
// Depends on kerf_pkg, the router RTL and kerf_event_checker.
module tb_keyboard_event_router_fifo;
	import kerf_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic       cmd;
	logic [7:0] status;
	logic [7:0] scancode;
	logic       owner_present;
	logic       cfg_we;
	logic       cfg_data;
	logic       done;
	logic [2:0] kind;
	logic [6:0] key_char;
	logic [7:0] out_status;
	logic [7:0] out_scancode;
	int         fail_count;
	int         outstanding;
	int         checked;
	logic [5:0] kinds_seen;
	int         requests_sent;
	int         idle_pct;
	int         phases_run;

	keyboard_event_router_fifo i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.status(status),
		.scancode(scancode),
		.owner_present(owner_present),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.done(done),
		.kind(kind),
		.key_char(key_char),
		.out_status(out_status),
		.out_scancode(out_scancode)
	);

	kerf_event_checker i_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.status(status),
		.scancode(scancode),
		.owner_present(owner_present),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.done(done),
		.kind(kind),
		.key_char(key_char),
		.out_status(out_status),
		.out_scancode(out_scancode),
		.fail_count(fail_count),
		.outstanding(outstanding),
		.checked(checked),
		.kinds_seen(kinds_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Holds one request on the inputs until the block takes it.
	task automatic issue(input cmd_t c, input logic [7:0] st, input logic [7:0] sc,
			input logic owner);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		status <= st;
		scancode <= sc;
		owner_present <= owner;
		do @(posedge clk); while (busy);
		requests_sent++;
	endtask

	// The extra edge lets the checker register the request taken at this edge.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_attention(input logic enable);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= enable;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] random_key();
		logic [7:0] code;
		case ($urandom_range(9))
			0: code = LSHIFT_MAKE;
			1: code = RSHIFT_MAKE;
			2: code = $urandom_range(1) ? LSHIFT_BREAK : RSHIFT_BREAK;
			3, 4, 5, 6: code = 8'h80 | 8'($urandom_range(8'h35, 2));
			7: code = 8'h80 | 8'($urandom_range(127));
			8: code = 8'($urandom_range(127));
			default: code = 8'($urandom_range(255));
		endcase
		return code;
	endfunction

	// Hold scroll lock, type a few keys, usually let it go again.
	task automatic attention_session();
		int         n;
		logic [7:0] st;
		n = $urandom_range(10, 1);
		issue(CMD_BYTE, 8'($urandom_range(31)), 8'h46, $urandom_range(99) < 90);
		repeat (n) begin
			st = ($urandom_range(99) < 85) ? 8'($urandom_range(31)) : 8'($urandom_range(255));
			if ($urandom_range(99) < 10)
				issue(CMD_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
			else
				issue(CMD_BYTE, st, random_key(), $urandom_range(99) < 90);
		end
		if ($urandom_range(99) < 85)
			issue(CMD_BYTE, 8'($urandom_range(31)), 8'hc6, 1'b1);
	endtask

	// Dirty status keeps these bytes out of the attention logic, so the ring
	// overflows; the reads then empty it and fall through to the live inputs.
	task automatic fill_and_empty_ring();
		logic [7:0] st;
		repeat (64) begin
			st = 8'($urandom_range(255));
			if ((st & DIRTY_MASK) == 8'h00)
				st[6] = 1'b1;
			issue(CMD_BYTE, st, 8'($urandom_range(255)), 1'b1);
		end
		repeat (64)
			issue(CMD_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
				1'($urandom_range(1)));
	endtask

	task automatic run_phase(input logic enable, input int pct, input logic with_fill);
		int first;
		int pick;
		set_attention(enable);
		idle_pct = pct;
		if (with_fill)
			fill_and_empty_ring();
		first = requests_sent;
		while (requests_sent - first < 48) begin
			pick = $urandom_range(99);
			if (pick < 45)
				attention_session();
			else if (pick < 75)
				repeat ($urandom_range(4, 1))
					issue(cmd_t'($urandom_range(1)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 1'($urandom_range(1)));
			else
				repeat ($urandom_range(6, 1))
					issue(CMD_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
						1'($urandom_range(1)));
		end
		phases_run++;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = 1'b0;
		status = 8'h00;
		scancode = 8'h00;
		owner_present = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 1'b0;
		idle_pct = 0;
		requests_sent = 0;
		phases_run = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, attention enabled from reset.
		issue(CMD_READ, 8'hff, 8'h00, 1'b0);
		issue(CMD_READ, 8'h00, 8'hff, 1'b1);
		issue(CMD_BYTE, 8'h00, 8'h1e, 1'b1);
		issue(CMD_BYTE, 8'hff, 8'hff, 1'b1);
		issue(CMD_BYTE, 8'h00, 8'h10, 1'b0);
		issue(CMD_BYTE, 8'h00, 8'h46, 1'b1);
		issue(CMD_BYTE, 8'h00, LSHIFT_MAKE, 1'b1);
		issue(CMD_BYTE, 8'h00, 8'h9e, 1'b1);
		issue(CMD_BYTE, 8'h00, LSHIFT_BREAK, 1'b1);
		issue(CMD_BYTE, 8'h00, 8'h9e, 1'b1);
		issue(CMD_BYTE, 8'h00, RSHIFT_MAKE, 1'b1);
		issue(CMD_BYTE, 8'h00, 8'h8b, 1'b1);
		issue(CMD_BYTE, 8'h1f, RSHIFT_BREAK, 1'b1);
		issue(CMD_BYTE, 8'h00, 8'hd6, 1'b1);
		issue(CMD_BYTE, 8'h00, 8'hff, 1'b1);
		issue(CMD_BYTE, 8'h00, 8'h1e, 1'b1);
		issue(CMD_BYTE, 8'h20, 8'h1e, 1'b1);
		issue(CMD_BYTE, 8'h00, 8'hc6, 1'b0);
		issue(CMD_BYTE, 8'h00, 8'h9e, 1'b1);
		repeat (6)
			issue(CMD_READ, 8'h5a, 8'ha5, 1'b0);

		run_phase(1'b1, 0, 1'b1);
		run_phase(1'b0, 78, 1'b0);
		run_phase(1'b1, 0, 1'b1);
		run_phase(1'b0, 11, 1'b0);
		run_phase(1'b1, 11, 1'b1);
		drain();

		$display("%0d requests in %0d phases, attention enable set to 0 and 1;",
			requests_sent, phases_run);
		$display("%0d results checked.", checked);
		$display("Result kinds seen, one bit per kind from queued upwards: %b", kinds_seen);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/kerf_pkg.sv
hw/rtl/kerf_ring.sv
hw/rtl/kerf_route.sv
hw/rtl/keyboard_event_router_fifo.sv
tb/sv/kerf_event_checker.sv
tb/sv/tb_keyboard_event_router_fifo.sv
